/* src/pid_controller_step_top_assert.svh */
// Assertion macros used by the PID controller step top level.
`ifndef PID_CONTROLLER_STEP_TOP_ASSERT_SVH
`define PID_CONTROLLER_STEP_TOP_ASSERT_SVH

// Checked only while reset is released.
`define PIDC_ASSERT_RUN(lbl, ck, rn, pr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) pr) \
    else $error("pid_controller_step: check failed");

// Checked on every edge, reset included.
`define PIDC_ASSERT_ALWAYS(lbl, ck, pr) \
  lbl: assert property (@(posedge ck) pr) \
    else $error("pid_controller_step: check failed during reset");

`endif

/* src/pidc_pkg.sv */
// Types and constants for the PID controller step.
`timescale 1ns / 1ps
package pidc_pkg;

  localparam int GAIN_W = 16;
  localparam int ACC_W  = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7fff_ffff;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DERIV_GAIN = 2'd2;

  // Signed Q8.8 gain set
  typedef struct packed {
    logic signed [GAIN_W-1:0] prop;
    logic signed [GAIN_W-1:0] integ;
    logic signed [GAIN_W-1:0] deriv;
  } pidc_gains_t;

endpackage

/* src/pid_controller_step_top.sv */
// Top level of the fixed-point discrete PID controller step.
`timescale 1ns / 1ps
`include "pid_controller_step_top_assert.svh"
// Usage:
//   Input stream (in_*): one transaction carries a setpoint and a measured
//   sample. Each transaction yields exactly one result transaction on the
//   output stream (out_*): drive, error, updated integral and clip flag.
//   Configuration (cfg_*): write the three Q8.8 gains by index while the
//   block is idle; index 3 is ignored. Gains reset to zero.
//   Results: an accepted transaction is held in the stage A registers, then in
//   the output register, whose valid bit drives out_tvalid.
//   The error, integral update and derivative form the first stage; the three
//   gain multipliers with the sum and saturation form the second stage.
//   Throughput: one transaction per cycle while out_tready holds. The integral and
//   previous-error registers close their loop through one add and clamp per accepted input.
//   Reset (rst_n low, synchronous): clears the integral, the previous
//   error, the gains and both pipeline valids.
//   Receiver stall: the result holds on out_tdata; the first stage keeps
//   taking one more transaction, then in_tready drops until out_tready.
module pid_controller_step_top
  import pidc_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata fields, low bit up: setpoint, measured
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  // out_tdata fields, low bit up: drive, error_now, integral_now, clipped
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [((SAMPLE_WIDTH+66+7)/8)*8-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [GAIN_W-1:0]     cfg_wdata
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int ERR_W  = SW + 1;
  localparam int DER_W  = SW + 2;
  localparam int ISUM_W = ((ERR_W > ACC_W) ? ERR_W : ACC_W) + 1;

  // Gains
  pidc_gains_t gains_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PROP_GAIN:  gains_r.prop  <= $signed(cfg_wdata);
        CFG_INTEG_GAIN: gains_r.integ <= $signed(cfg_wdata);
        CFG_DERIV_GAIN: gains_r.deriv <= $signed(cfg_wdata);
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  // Handshake: advance the output register when empty or drained
  logic a_vld_r;
  logic out_vld_r;
  logic adv;
  logic in_acc;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !a_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // Stage A: error, integral update, derivative
  logic signed [SW-1:0]     sp;
  logic signed [SW-1:0]     ms;
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [DER_W-1:0]  deriv_nxt;
  logic signed [ISUM_W-1:0] isum;
  logic signed [ACC_W-1:0]  integ_nxt;
  logic                     isat_nxt;

  logic signed [ACC_W-1:0]  integ_r;
  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [ERR_W-1:0]  a_err_r;
  logic signed [DER_W-1:0]  a_deriv_r;
  logic signed [ACC_W-1:0]  a_integ_r;
  logic                     a_isat_r;

  always_comb begin
    sp        = $signed(in_tdata[SW-1:0]);
    ms        = $signed(in_tdata[2*SW-1:SW]);
    err_nxt   = ERR_W'(sp) - ERR_W'(ms);
    deriv_nxt = DER_W'(err_nxt) - DER_W'(prev_err_r);
    isum      = ISUM_W'(integ_r) + ISUM_W'(err_nxt);
    if (isum > ISUM_W'(ACC_MAX)) begin
      integ_nxt = ACC_MAX;
      isat_nxt  = 1'b1;
    end else if (isum < ISUM_W'(ACC_MIN)) begin
      integ_nxt = ACC_MIN;
      isat_nxt  = 1'b1;
    end else begin
      integ_nxt = isum[ACC_W-1:0];
      isat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
      a_vld_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        integ_r    <= integ_nxt;
        prev_err_r <= err_nxt;
        a_vld_r    <= 1'b1;
      end else if (adv) begin
        a_vld_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_err_r   <= err_nxt;
      a_deriv_r <= deriv_nxt;
      a_integ_r <= integ_nxt;
      a_isat_r  <= isat_nxt;
    end
  end

  // Stage B: drive computation into the output register
  logic                    load_out;
  logic signed [ACC_W-1:0] drive_r;
  logic                    dclip_r;
  logic signed [ERR_W-1:0] o_err_r;
  logic signed [ACC_W-1:0] o_integ_r;
  logic                    o_isat_r;

  assign load_out = a_vld_r && adv;

  pidc_drive #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_drive (
    .clk    (clk),
    .load   (load_out),
    .gains  (gains_r),
    .err    (a_err_r),
    .deriv  (a_deriv_r),
    .integ  (a_integ_r),
    .drive_r(drive_r),
    .clip_r (dclip_r)
  );

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_err_r   <= a_err_r;
      o_integ_r <= a_integ_r;
      o_isat_r  <= a_isat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= a_vld_r;
    end
  end

  assign out_tvalid = out_vld_r;

  always_comb begin
    out_tdata                         = '0;
    out_tdata[ACC_W-1:0]              = drive_r;
    out_tdata[ACC_W+ERR_W-1:ACC_W]    = o_err_r;
    out_tdata[2*ACC_W+ERR_W-1:ACC_W+ERR_W] = o_integ_r;
    out_tdata[2*ACC_W+ERR_W]          = o_isat_r | dclip_r;
  end

  // Checks
  `PIDC_ASSERT_ALWAYS(a_rst_clears, clk, !rst_n |=> (!out_tvalid && !a_vld_r))
  `PIDC_ASSERT_RUN(a_integ_tracks, clk, rst_n, in_acc |=> (a_integ_r == integ_r))
  `PIDC_ASSERT_RUN(a_isat_at_limit, clk, rst_n,
    (a_vld_r && a_isat_r) |-> (a_integ_r == ACC_MAX || a_integ_r == ACC_MIN))
  `PIDC_ASSERT_RUN(a_stage_moves, clk, rst_n, (a_vld_r && adv) |=> out_tvalid)

endmodule

/* src/pidc_drive.sv */
// Drive stage: three gain products, sum, arithmetic shift and saturation.
`timescale 1ns / 1ps
module pidc_drive
  import pidc_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          load,
  input  pidc_gains_t                   gains,
  input  logic signed [SAMPLE_WIDTH:0]   err,
  input  logic signed [SAMPLE_WIDTH+1:0] deriv,
  input  logic signed [ACC_W-1:0]       integ,
  output logic signed [ACC_W-1:0]       drive_r,
  output logic                          clip_r
);

  localparam int PE_W  = GAIN_W + SAMPLE_WIDTH + 1;
  localparam int PI_W  = GAIN_W + ACC_W;
  localparam int PD_W  = GAIN_W + SAMPLE_WIDTH + 2;
  localparam int PMAX  = (PI_W > PD_W) ? PI_W : PD_W;
  localparam int SUM_W = PMAX + 2;

  logic signed [PE_W-1:0]  prod_p;
  logic signed [PI_W-1:0]  prod_i;
  logic signed [PD_W-1:0]  prod_d;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] shifted;
  logic signed [ACC_W-1:0] drive_nxt;
  logic                    clip_nxt;

  always_comb begin
    prod_p  = gains.prop * err;
    prod_i  = gains.integ * integ;
    prod_d  = gains.deriv * deriv;
    sum     = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
    shifted = sum >>> GAIN_FRAC_BITS;
    // clamp to the signed 32-bit range
    if (shifted > SUM_W'(ACC_MAX)) begin
      drive_nxt = ACC_MAX;
      clip_nxt  = 1'b1;
    end else if (shifted < SUM_W'(ACC_MIN)) begin
      drive_nxt = ACC_MIN;
      clip_nxt  = 1'b1;
    end else begin
      drive_nxt = shifted[ACC_W-1:0];
      clip_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_r <= drive_nxt;
      clip_r  <= clip_nxt;
    end
  end

endmodule
